// ===== rtl/ethtab_pkg.sv =====
// Shared types and constants for the epoch-tagged pair-key hash table.
// No dependencies; imported by the top level, ethtab_ctrl and ethtab_dp.
`default_nettype none

package ethtab_pkg;

    localparam int KEY_W      = 32;
    localparam int EPOCH_W    = 32;
    localparam int JOB_W      = 11;
    localparam int MOD_BITS   = 4;
    localparam int MOD_STEPS  = KEY_W / MOD_BITS;
    localparam int HASH_SHIFT = 15;

    localparam logic [KEY_W-1:0] HASH_MUL_A = 32'h9E37_79B1;
    localparam logic [KEY_W-1:0] HASH_MUL_B = 32'h85EB_CA6B;

    typedef logic [JOB_W-1:0] t_job;

    typedef enum logic [1:0] {
        FN_BEGIN  = 2'd0,
        FN_INSERT = 2'd1,
        FN_SEAL   = 2'd2,
        FN_LOOKUP = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        ST_DONE     = 3'd0,
        ST_INSERTED = 3'd1,
        ST_PRESENT  = 3'd2,
        ST_FULL     = 3'd3,
        ST_FOUND    = 3'd4,
        ST_MISS     = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        JS_ZERO,
        JS_SLOT,
        JS_COUNT
    } t_jsel;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_READ,
        S_CHECK
    } t_state;

    typedef struct packed {
        logic [KEY_W-1:0]   obj;
        logic [KEY_W-1:0]   owner;
        logic [EPOCH_W-1:0] epoch;
        t_job               job;
    } t_slot;

    // controller -> datapath
    typedef struct packed {
        logic    load;
        logic    begin_frame;
        logic    seal;
        logic    clr_init;
        logic    clr_step;
        logic    hash_step;
        logic    probe_rd;
        logic    probe_next;
        logic    insert;
        logic    emit;
        t_status status;
        t_jsel   jsel;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic frame_open;
        logic jobs_full;
        logic epoch_max;
        logic hash_done;
        logic clr_last;
        logic slot_free;
        logic slot_match;
        logic probe_last;
    } t_stat;

endpackage

`default_nettype wire

// ===== rtl/epoch_tagged_pair_key_hash_table.sv =====
// Top level of the epoch-tagged pair-key hash table.
// Depends on ethtab_pkg, ethtab_ctrl, ethtab_dp (which holds ethtab_ram).
`default_nettype none

// A request is taken when start is high and busy is low; every request gives
// exactly one result, shown for one cycle with o_valid, and the receiver cannot
// stall it. Begin frame, seal, an insert with the job budget spent and a lookup
// in a closed frame answer in the cycle after the request. Insert and lookup
// hash the key pair (two 32x32 multiplies registered at acceptance), then probe
// the slot RAM one slot a cycle: the result shows in the cycle in which busy
// drops, so a new request can follow. A table size that is not a power of two
// adds a restoring remainder reduction to the hash state. After reset, and
// when a begin frame wraps the epoch, busy stays high for a clearing pass
// over every slot of the slot RAM.
module epoch_tagged_pair_key_hash_table #(
    parameter int TABLE_SLOTS = 4096,
    parameter int MAX_JOBS    = 1536
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [1:0]                    i_func,
    input  wire logic [ethtab_pkg::KEY_W-1:0]  i_key_object,
    input  wire logic [ethtab_pkg::KEY_W-1:0]  i_key_owner,
    output logic                               o_valid,
    output logic [2:0]                         o_status,
    output logic [ethtab_pkg::JOB_W-1:0]       o_job_index
);

    import ethtab_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    ethtab_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_func  (i_func),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .busy    (busy)
    );

    ethtab_dp #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .MAX_JOBS    (MAX_JOBS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_key_object (i_key_object),
        .i_key_owner  (i_key_owner),
        .o_valid      (o_valid),
        .o_status     (o_status),
        .o_job_index  (o_job_index)
    );

endmodule

`default_nettype wire

// ===== rtl/ethtab_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module ethtab_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/ethtab_ctrl.sv =====
// Controller state machine: request sequencing, clearing pass, probe loop.
// Depends on ethtab_pkg.
`default_nettype none

module ethtab_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    input  wire logic [1:0]         i_func,
    input  wire ethtab_pkg::t_stat  i_stat,
    output ethtab_pkg::t_cmd        o_cmd,
    output logic                    busy
);

    import ethtab_pkg::*;

    t_state r_state, n_state;
    t_func  r_func;
    t_func  func_in;
    logic   accept;
    logic   is_ins;
    t_cmd   cmd;

    assign func_in = t_func'(i_func);
    assign accept  = start && (r_state == S_IDLE);
    assign is_ins  = (r_func == FN_INSERT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_func  <= FN_BEGIN;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_func <= func_in;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_stat.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (accept) begin
                    unique case (func_in)
                        FN_BEGIN:  if (i_stat.epoch_max) n_state = S_CLEAR;
                        FN_INSERT: if (!i_stat.jobs_full) n_state = S_HASH;
                        FN_SEAL:   n_state = S_IDLE;
                        FN_LOOKUP: if (i_stat.frame_open) n_state = S_HASH;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_HASH: begin
                if (i_stat.hash_done) n_state = S_READ;
            end
            S_READ: n_state = S_CHECK;
            S_CHECK: begin
                if (i_stat.slot_free || i_stat.slot_match || i_stat.probe_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        cmd        = '0;
        cmd.status = ST_DONE;
        cmd.jsel   = JS_ZERO;
        unique case (r_state)
            S_CLEAR: cmd.clr_step = 1'b1;
            S_IDLE: begin
                if (accept) begin
                    unique case (func_in)
                        FN_BEGIN: begin
                            cmd.begin_frame = 1'b1;
                            cmd.clr_init    = i_stat.epoch_max;
                            cmd.emit        = 1'b1;
                        end
                        FN_INSERT: begin
                            if (i_stat.jobs_full) begin
                                cmd.emit   = 1'b1;
                                cmd.status = ST_FULL;
                            end else begin
                                cmd.load = 1'b1;
                            end
                        end
                        FN_SEAL: begin
                            cmd.seal = 1'b1;
                            cmd.emit = 1'b1;
                        end
                        FN_LOOKUP: begin
                            if (i_stat.frame_open) begin
                                cmd.load = 1'b1;
                            end else begin
                                cmd.emit   = 1'b1;
                                cmd.status = ST_MISS;
                            end
                        end
                        default: cmd.emit = 1'b0;
                    endcase
                end
            end
            S_HASH: cmd.hash_step = 1'b1;
            S_READ: cmd.probe_rd = 1'b1;
            S_CHECK: begin
                priority if (i_stat.slot_free) begin
                    cmd.emit = 1'b1;
                    if (is_ins) begin
                        cmd.insert = 1'b1;
                        cmd.status = ST_INSERTED;
                        cmd.jsel   = JS_COUNT;
                    end else begin
                        cmd.status = ST_MISS;
                    end
                end else if (i_stat.slot_match) begin
                    cmd.emit   = 1'b1;
                    cmd.status = is_ins ? ST_PRESENT : ST_FOUND;
                    cmd.jsel   = JS_SLOT;
                end else if (i_stat.probe_last) begin
                    cmd.emit   = 1'b1;
                    cmd.status = is_ins ? ST_FULL : ST_MISS;
                end else begin
                    cmd.probe_next = 1'b1;
                end
            end
            default: cmd.emit = 1'b0;
        endcase
    end

    assign o_cmd = cmd;
    assign busy  = (r_state != S_IDLE);

endmodule

`default_nettype wire

// ===== rtl/ethtab_dp.sv =====
// Datapath: key hashing, slot store, epoch and job counters, result register.
// Depends on ethtab_pkg and ethtab_ram.
`default_nettype none

module ethtab_dp #(
    parameter int TABLE_SLOTS = 4096,
    parameter int MAX_JOBS    = 1536
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire ethtab_pkg::t_cmd           i_cmd,
    output ethtab_pkg::t_stat               o_stat,
    input  wire logic [ethtab_pkg::KEY_W-1:0] i_key_object,
    input  wire logic [ethtab_pkg::KEY_W-1:0] i_key_owner,
    output logic                            o_valid,
    output logic [2:0]                      o_status,
    output logic [ethtab_pkg::JOB_W-1:0]    o_job_index
);

    import ethtab_pkg::*;

    localparam int AW = $clog2(TABLE_SLOTS);
    localparam int CW = $clog2(MAX_JOBS + 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_SLOTS - 1);
    localparam logic [CW-1:0] JOBS_MAX  = CW'(MAX_JOBS);
    localparam bit POW2 = ((TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0);

    logic [EPOCH_W-1:0] r_epoch;
    logic [CW-1:0]      r_count;
    logic               r_open;
    logic [AW-1:0]      r_clr;
    logic [AW-1:0]      r_addr;
    logic [AW-1:0]      r_probe_n;
    logic [KEY_W-1:0]   r_key_a, r_key_b;
    logic [KEY_W-1:0]   r_pa, r_pb;
    logic               r_valid;
    t_status            r_status;
    t_job               r_job;

    logic [KEY_W-1:0]   h_xor, h_mix;
    logic [AW-1:0]      hash_addr;
    logic               hash_done;
    logic [AW-1:0]      addr_next;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr, ram_raddr;
    t_slot              ram_wdata, ram_rdata;
    t_job               n_job;

    assign h_xor = r_pa ^ r_pb;
    assign h_mix = h_xor ^ (h_xor >> HASH_SHIFT);

    generate
        if (POW2) begin : g_mask
            assign hash_addr = h_mix[AW-1:0];
            assign hash_done = 1'b1;
        end else begin : g_reduce
            // remainder by restoring reduction, MOD_BITS hash bits per cycle
            localparam int MCW = $clog2(MOD_STEPS);
            localparam logic [AW:0] SLOTS_R = (AW+1)'(TABLE_SLOTS);
            localparam logic [MCW-1:0] LAST_STEP = MCW'(MOD_STEPS - 1);

            logic [MCW-1:0]      r_mcnt;
            logic [AW:0]         r_rem;
            logic [AW:0]         rem_next;
            logic [MOD_BITS-1:0] nib;

            assign nib = h_mix[(MOD_STEPS - 1 - int'(r_mcnt)) * MOD_BITS +: MOD_BITS];

            always_comb begin
                rem_next = r_rem;
                for (int i = 0; i < MOD_BITS; i++) begin
                    rem_next = {rem_next[AW-1:0], nib[MOD_BITS-1-i]};
                    if (rem_next >= SLOTS_R) rem_next = rem_next - SLOTS_R;
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_mcnt <= '0;
                end else if (i_cmd.load) begin
                    r_mcnt <= '0;
                end else if (i_cmd.hash_step) begin
                    r_mcnt <= r_mcnt + 1'b1;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_cmd.load) begin
                    r_rem <= '0;
                end else if (i_cmd.hash_step) begin
                    r_rem <= rem_next;
                end
            end

            assign hash_addr = rem_next[AW-1:0];
            assign hash_done = (r_mcnt == LAST_STEP);
        end
    endgenerate

    assign addr_next = (r_addr == LAST_ADDR) ? '0 : r_addr + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_epoch <= '0;
            r_count <= '0;
            r_open  <= 1'b0;
            r_clr   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit;
            if (i_cmd.begin_frame) begin
                r_count <= '0;
                r_open  <= 1'b0;
                r_epoch <= (r_epoch == '1) ? EPOCH_W'(1) : r_epoch + 1'b1;
            end else if (i_cmd.insert) begin
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.seal && (r_count != '0)) begin
                r_open <= 1'b1;
            end
            if (i_cmd.clr_init) begin
                r_clr <= '0;
            end else if (i_cmd.clr_step) begin
                r_clr <= r_clr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key_a   <= i_key_object;
            r_key_b   <= i_key_owner;
            r_pa      <= i_key_object * HASH_MUL_A;
            r_pb      <= i_key_owner * HASH_MUL_B;
            r_probe_n <= '0;
        end else if (i_cmd.probe_next) begin
            r_probe_n <= r_probe_n + 1'b1;
        end
        if (i_cmd.hash_step) begin
            r_addr <= hash_addr;
        end else if (i_cmd.probe_next) begin
            r_addr <= addr_next;
        end
        if (i_cmd.emit) begin
            r_status <= i_cmd.status;
            r_job    <= n_job;
        end
    end

    always_comb begin
        unique case (i_cmd.jsel)
            JS_SLOT:  n_job = ram_rdata.job;
            JS_COUNT: n_job = t_job'(r_count);
            default:  n_job = '0;
        endcase
    end

    // in the check state the next slot is read ahead, one probe a cycle
    assign ram_raddr = i_cmd.probe_rd ? r_addr : addr_next;
    assign ram_we    = i_cmd.clr_step || i_cmd.insert;
    assign ram_waddr = i_cmd.clr_step ? r_clr : r_addr;

    always_comb begin
        if (i_cmd.clr_step) begin
            ram_wdata = '0;
        end else begin
            ram_wdata.obj   = r_key_a;
            ram_wdata.owner = r_key_b;
            ram_wdata.epoch = r_epoch;
            ram_wdata.job   = t_job'(r_count);
        end
    end

    ethtab_ram #(
        .WIDTH ($bits(t_slot)),
        .DEPTH (TABLE_SLOTS)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        o_stat.frame_open = r_open;
        o_stat.jobs_full  = (r_count >= JOBS_MAX);
        o_stat.epoch_max  = (r_epoch == '1);
        o_stat.hash_done  = hash_done;
        o_stat.clr_last   = (r_clr == LAST_ADDR);
        o_stat.slot_free  = (ram_rdata.epoch != r_epoch);
        o_stat.slot_match = (ram_rdata.obj == r_key_a) && (ram_rdata.owner == r_key_b);
        o_stat.probe_last = (r_probe_n == LAST_ADDR);
    end

    assign o_valid     = r_valid;
    assign o_status    = r_status;
    assign o_job_index = r_job;

`ifndef SYNTHESIS
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.insert |=> r_count == $past(r_count) + 1'b1)
        else $error("job counter did not advance on insert");

    a_epoch_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.begin_frame |=> r_epoch != '0)
        else $error("epoch zero after begin frame");

    a_write_tag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && !i_cmd.clr_step) |-> (ram_wdata.epoch == r_epoch && r_epoch != '0))
        else $error("slot written with a stale epoch");

    a_slot_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && i_cmd.jsel == JS_SLOT) |-> (o_stat.slot_match && !o_stat.slot_free))
        else $error("stored job reported from a non-matching slot");
`endif

endmodule

`default_nettype wire
